### hdl/conv3x3_vertical_edge_assert.svh
// assertion macros for the vertical edge filter
`ifndef CONV3X3_VERTICAL_EDGE_ASSERT_SVH
`define CONV3X3_VERTICAL_EDGE_ASSERT_SVH

// consequence holds in the cycle after the condition
`define C3VE_ASSERT_NEXT(lbl, clk, rstn, cond, conseq, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (conseq)) \
        else $error(msg);

// consequence holds in the same cycle as the condition
`define C3VE_ASSERT_SAME(lbl, clk, rstn, cond, conseq, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (conseq)) \
        else $error(msg);

`endif

### hdl/c3ve_pkg.sv
package c3ve_pkg;

    // default frame limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // field widths
    localparam int PIX_W   = 8;
    localparam int SUM_W   = 11;
    localparam int COORD_W = 10;
    localparam int CFG_W   = 11;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    // configuration register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    // reset values of the size registers
    localparam logic [CFG_W-1:0] CFG_WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_W-1:0] CFG_HEIGHT_RESET = 11'd1024;

    // smallest frame side that holds a full window
    localparam int MIN_SIDE = 3;

endpackage

### hdl/conv3x3_vertical_edge.sv
// 3x3 horizontal-gradient filter (columns 1,0,-1) over a raster pixel stream.
// A pixel's result is registered in the window stage, then in the output register.
// Throughput: one pixel per cycle unless m_tready stalls the output; set by the
// single line memory, read at acceptance and written back with a forwarding path.
// Reset (aresetn low, synchronous): counters, window, valids cleared, sizes 1024;
// the line memory is not cleared and needs no clearing pass.
`include "conv3x3_vertical_edge_assert.svh"

module conv3x3_vertical_edge #(
    parameter int MAX_WIDTH  = c3ve_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = c3ve_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // pixel input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [c3ve_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] pixel_value
    input  logic                             s_tuser,   // [0] frame_start
    // result output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [10:0] gradient_sum, [18:11] clamped_value, [28:19] center_column,
    // [38:29] center_row, [39] zero
    output logic [c3ve_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                             m_tlast,   // frame_last
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_index,
    input  logic [c3ve_pkg::CFG_W-1:0]       cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WSZ_W = $clog2(MAX_WIDTH + 1);
    localparam int HSZ_W = $clog2(MAX_HEIGHT + 1);
    localparam int PW    = c3ve_pkg::PIX_W;
    localparam int SW    = c3ve_pkg::SUM_W;
    localparam int CW    = c3ve_pkg::COORD_W;

    // configuration registers
    logic [c3ve_pkg::CFG_W-1:0] width_reg;
    logic [c3ve_pkg::CFG_W-1:0] height_reg;
    logic [WSZ_W-1:0]           w_eff;
    logic [HSZ_W-1:0]           h_eff;

    // position counters
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_base;
    logic [ROW_W-1:0] row_base;
    logic [COL_W-1:0] c_cur;
    logic [ROW_W-1:0] r_cur;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;
    logic             col_wrap;
    logic             emit0;
    logic             last0;

    // line memory: [15:8] upper row, [7:0] middle row
    logic [2*PW-1:0] line_mem [MAX_WIDTH];
    logic [2*PW-1:0] rd_word_reg;
    logic [2*PW-1:0] fwd_word_reg;
    logic [2*PW-1:0] word1;

    // window stage
    logic             s1_valid_reg;
    logic [PW-1:0]    s1_px_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_emit_reg;
    logic             s1_last_reg;
    logic             s1_fwd_reg;
    logic [PW-1:0]    taps_reg [6];
    logic [PW-1:0]    top1;
    logic [PW-1:0]    mid1;
    logic [PW+1:0]    left_sum;
    logic [PW+1:0]    right_sum;
    logic signed [SW-1:0] grad;
    logic [PW-1:0]    clamp;

    // output register
    logic          m_valid_reg;
    logic [SW-1:0] m_sum_reg;
    logic [PW-1:0] m_clamp_reg;
    logic [CW-1:0] m_col_reg;
    logic [CW-1:0] m_row_reg;
    logic          m_last_reg;

    // handshakes
    logic s_fire;
    logic out_free;
    logic s1_adv;

    assign out_free  = !m_valid_reg || m_tready;
    assign s1_adv    = s1_valid_reg && out_free;
    assign s_tready  = !s1_valid_reg || out_free;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= c3ve_pkg::CFG_WIDTH_RESET;
            height_reg <= c3ve_pkg::CFG_HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                c3ve_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                c3ve_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective frame size
    always_comb begin
        if (32'(width_reg) < 32'(c3ve_pkg::MIN_SIDE)) begin
            w_eff = WSZ_W'(c3ve_pkg::MIN_SIDE);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WSZ_W'(MAX_WIDTH);
        end else begin
            w_eff = WSZ_W'(width_reg);
        end
        if (32'(height_reg) < 32'(c3ve_pkg::MIN_SIDE)) begin
            h_eff = HSZ_W'(c3ve_pkg::MIN_SIDE);
        end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = HSZ_W'(MAX_HEIGHT);
        end else begin
            h_eff = HSZ_W'(height_reg);
        end
    end

    // position of the incoming pixel and the next one
    always_comb begin
        col_base = s_tuser ? '0 : col_reg;
        row_base = s_tuser ? '0 : row_reg;
        c_cur    = (32'(col_base) >= 32'(w_eff)) ? '0 : col_base;
        r_cur    = (32'(row_base) >= 32'(h_eff)) ? '0 : row_base;
        emit0    = (32'(c_cur) >= 32'd2) && (32'(r_cur) >= 32'd2);
        last0    = (32'(c_cur) == 32'(w_eff) - 32'd1) && (32'(r_cur) == 32'(h_eff) - 32'd1);
        col_wrap = (32'(c_cur) + 32'd1) >= 32'(w_eff);
        col_next = col_wrap ? '0 : COL_W'(32'(c_cur) + 32'd1);
        if (col_wrap) begin
            row_next = ((32'(r_cur) + 32'd1) >= 32'(h_eff)) ? '0 : ROW_W'(32'(r_cur) + 32'd1);
        end else begin
            row_next = r_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_fire) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line memory: read at acceptance, write back as the window stage moves
    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            line_mem[s1_col_reg] <= {mid1, s1_px_reg};
        end
        if (s_fire) begin
            rd_word_reg <= line_mem[c_cur];
        end
    end

    // window stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end else if (s_fire) begin
            s1_valid_reg <= 1'b1;
            s1_fwd_reg   <= s1_valid_reg && (s1_col_reg == c_cur);
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end
    end

    // window stage payload and forwarded write data
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_px_reg    <= s_tdata[PW-1:0];
            s1_col_reg   <= c_cur;
            s1_row_reg   <= r_cur;
            s1_emit_reg  <= emit0;
            s1_last_reg  <= last0;
            fwd_word_reg <= {mid1, s1_px_reg};
        end
    end

    // column sums and saturation
    always_comb begin
        word1     = s1_fwd_reg ? fwd_word_reg : rd_word_reg;
        top1      = word1[2*PW-1:PW];
        mid1      = word1[PW-1:0];
        left_sum  = (PW+2)'(taps_reg[3]) + (PW+2)'(taps_reg[4]) + (PW+2)'(taps_reg[5]);
        right_sum = (PW+2)'(top1) + (PW+2)'(mid1) + (PW+2)'(s1_px_reg);
        grad      = $signed(SW'(left_sum)) - $signed(SW'(right_sum));
        if (grad[SW-1]) begin
            clamp = '0;
        end else if (grad > $signed(SW'(255))) begin
            clamp = '1;
        end else begin
            clamp = grad[PW-1:0];
        end
    end

    // window taps shift one column per pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                taps_reg[i] <= '0;
            end
        end else if (s1_adv) begin
            taps_reg[3] <= taps_reg[0];
            taps_reg[4] <= taps_reg[1];
            taps_reg[5] <= taps_reg[2];
            taps_reg[0] <= top1;
            taps_reg[1] <= mid1;
            taps_reg[2] <= s1_px_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_emit_reg) begin
            m_sum_reg   <= grad;
            m_clamp_reg <= clamp;
            m_col_reg   <= CW'(32'(s1_col_reg) - 32'd1);
            m_row_reg   <= CW'(32'(s1_row_reg) - 32'd1);
            m_last_reg  <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_row_reg, m_col_reg, m_clamp_reg, m_sum_reg};
    assign m_tlast  = m_last_reg;

    // checks
    `C3VE_ASSERT_NEXT(a_accept_fills_window, aclk, aresetn, s_fire, s1_valid_reg,
        "accepted pixel did not reach the window stage")
    `C3VE_ASSERT_NEXT(a_emit_reaches_output, aclk, aresetn, s1_adv && s1_emit_reg,
        m_valid_reg, "interior result lost between window and output")
    `C3VE_ASSERT_SAME(a_negative_clamps_zero, aclk, aresetn, m_tvalid && m_tdata[SW-1],
        m_tdata[SW+PW-1:SW] == '0, "negative sum not clamped to zero")

endmodule

### tb/sv/conv3x3_vertical_edge_tb.sv
module conv3x3_vertical_edge_tb;

    localparam int MAX_W        = c3ve_pkg::DEF_MAX_WIDTH;
    localparam int MAX_H        = c3ve_pkg::DEF_MAX_HEIGHT;
    localparam int PIX_W        = c3ve_pkg::PIX_W;
    localparam int SUM_W        = c3ve_pkg::SUM_W;
    localparam int COORD_W      = c3ve_pkg::COORD_W;
    localparam int CFG_W        = c3ve_pkg::CFG_W;
    localparam int MIN_SIDE     = c3ve_pkg::MIN_SIDE;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES  = 10;
    localparam int CYCLE_LIMIT  = 300000;

    // one gradient result, laid out as {m_tlast, m_tdata[38:0]}
    typedef struct packed {
        logic                   last;
        logic [COORD_W-1:0]     row;
        logic [COORD_W-1:0]     col;
        logic [PIX_W-1:0]       clamp;
        logic signed [SUM_W-1:0] gsum;
    } gradient_t;

    logic                                 aclk      = 1'b0;
    logic                                 aresetn   = 1'b0;
    logic                                 s_tvalid  = 1'b0;
    logic                                 s_tready;
    logic [c3ve_pkg::IN_TDATA_W-1:0]      s_tdata   = '0;
    logic                                 s_tuser   = 1'b0;
    logic                                 m_tvalid;
    logic                                 m_tready  = 1'b0;
    logic [c3ve_pkg::OUT_TDATA_W-1:0]     m_tdata;
    logic                                 m_tlast;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic                                 cfg_index = c3ve_pkg::CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0]                     cfg_data  = '0;

    conv3x3_vertical_edge dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // gradient predictor state: line stores, window taps, position, sizes
    logic [PIX_W-1:0] upper_row  [MAX_W] = '{default: '0};
    logic [PIX_W-1:0] middle_row [MAX_W] = '{default: '0};
    logic [PIX_W-1:0] taps       [6]     = '{default: '0};
    int               col_pos    = 0;
    int               row_pos    = 0;
    logic [CFG_W-1:0] width_reg  = c3ve_pkg::CFG_WIDTH_RESET;
    logic [CFG_W-1:0] height_reg = c3ve_pkg::CFG_HEIGHT_RESET;

    gradient_t expected_results [$];

    // pacing and bookkeeping
    int src_idle_pct    = 0;
    int sink_stall_pct  = 0;
    int hold_cycles     = 0;
    bit restart_pending = 1'b0;
    int mismatch_count  = 0;
    int pixel_count     = 0;
    int result_count    = 0;
    int cycle_count     = 0;

    // size register value as the block uses it
    function automatic int effective_side(logic [CFG_W-1:0] raw, int limit);
        if (int'(raw) < MIN_SIDE)
            return MIN_SIDE;
        if (int'(raw) > limit)
            return limit;
        return int'(raw);
    endfunction

    // advance the filter by one accepted pixel and queue its result, if any
    function automatic void predict_gradient(logic [PIX_W-1:0] px, logic fs);
        int               w, h, c, r, left_sum, right_sum, diff;
        logic [PIX_W-1:0] top, mid;
        gradient_t        res;
        w = effective_side(width_reg, MAX_W);
        h = effective_side(height_reg, MAX_H);
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w)
            col_pos = 0;
        if (row_pos >= h)
            row_pos = 0;
        c = col_pos;
        r = row_pos;
        top = upper_row[c];
        mid = middle_row[c];
        left_sum  = int'(taps[3]) + int'(taps[4]) + int'(taps[5]);
        right_sum = int'(top) + int'(mid) + int'(px);
        // interior pixel one row and one column back
        if (c >= 2 && r >= 2) begin
            diff      = left_sum - right_sum;
            res.gsum  = diff[SUM_W-1:0];
            res.clamp = (diff < 0) ? 8'd0 : ((diff > 255) ? 8'd255 : diff[PIX_W-1:0]);
            res.col   = COORD_W'(c - 1);
            res.row   = COORD_W'(r - 1);
            res.last  = (c == w - 1) && (r == h - 1);
            expected_results.push_back(res);
        end
        // shift window and update line stores
        taps[3] = taps[0];
        taps[4] = taps[1];
        taps[5] = taps[2];
        taps[0] = top;
        taps[1] = mid;
        taps[2] = px;
        upper_row[c]  = mid;
        middle_row[c] = px;
        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h)
                row_pos = 0;
        end
    endfunction

    function automatic string describe(gradient_t g);
        return $sformatf("sum %0d clamp %0d col %0d row %0d last %0b",
                         g.gsum, g.clamp, g.col, g.row, g.last);
    endfunction

    // result checker
    always @(posedge aclk) begin
        gradient_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tlast, m_tdata[38:0]};
            result_count++;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: %s", describe(got));
            end else begin
                want = expected_results.pop_front();
                if (got.gsum !== want.gsum || got.clamp !== want.clamp ||
                    got.col !== want.col || got.row !== want.row ||
                    got.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected %s, got %s",
                                 describe(want), describe(got));
                end
            end
        end
    end

    // result receiver: random stalls, plus an occasional long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // one pixel request, with random source gaps in front of it
    task automatic send_pixel(logic [PIX_W-1:0] px, logic fs);
        logic fs_eff;
        fs_eff = fs | restart_pending;
        restart_pending = 1'b0;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tuser  <= fs_eff;
        do @(posedge aclk); while (s_tready !== 1'b1);
        pixel_count++;
        predict_gradient(px, fs_eff);
    endtask

    // random pixels, frame start on the first and now and then on others
    task automatic send_frame(int count, int noise_pct);
        for (int k = 0; k < count; k++)
            send_pixel(random_pixel(), (k == 0) || ($urandom_range(0, 99) < noise_pct));
    endtask

    // let everything in flight come out before touching the registers
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_frame_size(logic [CFG_W-1:0] w_raw, logic [CFG_W-1:0] h_raw);
        int old_w, new_w;
        wait_idle();
        old_w = effective_side(width_reg, MAX_W);
        new_w = effective_side(w_raw, MAX_W);
        cfg_valid <= 1'b1;
        cfg_index <= c3ve_pkg::CFG_IMAGE_WIDTH;
        cfg_data  <= w_raw;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        width_reg = w_raw;
        cfg_index <= c3ve_pkg::CFG_IMAGE_HEIGHT;
        cfg_data  <= h_raw;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        height_reg = h_raw;
        cfg_valid <= 1'b0;
        // a wider row needs two fresh rows before the stores are valid
        if (new_w > old_w)
            restart_pending = 1'b1;
    endtask

    // full positive and negative gradients and a mid-range one on 3x3 frames
    task automatic test_extremes();
        logic [PIX_W-1:0] left_px  [3] = '{8'd255, 8'd0,   8'd90};
        logic [PIX_W-1:0] right_px [3] = '{8'd0,   8'd255, 8'd17};
        set_frame_size(11'd3, 11'd3);
        for (int f = 0; f < 3; f++)
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    send_pixel((c == 0) ? left_px[f] : (c == 2) ? right_px[f] : random_pixel(),
                               (r == 0) && (c == 0));
    endtask

    // frame start in the middle of a frame, then a natural wrap into the next
    task automatic test_frame_restart();
        set_frame_size(11'd5, 11'd4);
        for (int k = 0; k < 33; k++)
            send_pixel(random_pixel(), (k == 0) || (k == 7));
    endtask

    // shrink both sizes while the position lies beyond them
    task automatic test_resize_mid_frame();
        set_frame_size(11'd8, 11'd8);
        send_frame(30, 0);
        set_frame_size(11'd5, 11'd3);
        for (int k = 0; k < 20; k++)
            send_pixel(random_pixel(), 1'b0);
    endtask

    // sizes below the minimum and above the maximum
    task automatic test_size_clamping();
        set_frame_size(11'd0, 11'd2);
        send_frame(9, 0);
        set_frame_size(11'd2, 11'd0);
        send_frame(9, 0);
        set_frame_size(11'd1, 11'd1);
        send_frame(9, 0);
        // oversized row: no window completes within the first row
        set_frame_size(11'd1025, 11'd2047);
        send_frame(40, 0);
    endtask

    // receiver holds off long enough for the input to stall
    task automatic test_backpressure();
        set_frame_size(11'd4, 11'd4);
        hold_cycles = 300;
        send_frame(80, 0);
    endtask

    // random sizes and frames under each pacing mode
    task automatic test_random();
        int src_pct  [4] = '{0, 51, 0, 7};
        int sink_pct [4] = '{0, 0, 51, 7};
        logic [CFG_W-1:0] w_raw, h_raw;
        for (int seg = 0; seg < 8; seg++) begin
            w_raw = ($urandom_range(0, 4) == 0) ? CFG_W'($urandom_range(0, 2))
                                                : CFG_W'($urandom_range(3, 16));
            case ($urandom_range(0, 6))
                0: h_raw = CFG_W'($urandom_range(0, 2));
                1: h_raw = CFG_W'($urandom_range(1025, 2047));
                default: h_raw = CFG_W'($urandom_range(3, 10));
            endcase
            set_frame_size(w_raw, h_raw);
            src_idle_pct   = src_pct[seg / 2];
            sink_stall_pct = sink_pct[seg / 2];
            send_frame(60, 3);
        end
        src_idle_pct   = 0;
        sink_stall_pct = 0;
    endtask

    // test sequence
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_frame_restart();
        test_resize_mid_frame();
        test_size_clamping();
        test_backpressure();
        test_random();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0)
            mismatch_count++;
        $display("covered %0d pixels and %0d results, frame sides 3 to 16 plus out-of-range sizes",
                 pixel_count, result_count);
        $display("pacing: free flow, source gaps, sink stalls, both, and a long sink hold-off");
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/c3ve_pkg.sv
hdl/conv3x3_vertical_edge.sv
tb/sv/conv3x3_vertical_edge_tb.sv
